[src/swh_pkg.sv]
// Shared constants, types and hash helpers for the string word hash index block.
// No dependencies; used by the interfaces and by string_word_hash_index_top.
package swh_pkg;

  localparam int WordBits = 32;
  localparam int ByteBits = 8;
  localparam int OutBits  = 12;
  localparam int CntBits  = 2;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [ByteBits-1:0] byte_t;
  typedef logic [OutBits-1:0]  index_t;
  typedef logic [CntBits-1:0]  cnt_t;

  localparam cnt_t WordFullCnt = cnt_t'(3);

  function automatic word_t sext_byte(input byte_t b);
    return {{(WordBits-ByteBits){b[ByteBits-1]}}, b};
  endfunction

  function automatic word_t fold_word(input word_t v);
    return v ^ (v >> 3);
  endfunction

  function automatic word_t mix_hash(input word_t h);
    return (h + (h >> 11)) + ((h >> 13) + (h >> 23));
  endfunction

endpackage

[src/swh_in_if.sv]
// Input channel carrying one string byte and its last-byte mark per request.
// Depends on swh_pkg.
interface swh_in_if;
  logic           valid;
  logic           ready;
  swh_pkg::byte_t data_byte;
  logic           last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[src/swh_out_if.sv]
// Result channel carrying one bucket index per request.
// Depends on swh_pkg.
interface swh_out_if;
  logic            valid;
  logic            ready;
  swh_pkg::index_t bucket_index;

  modport source (output valid, output bucket_index, input ready);
  modport sink (input valid, input bucket_index, output ready);
endinterface

[src/string_word_hash_index_top.sv]
// String word hash index: hashes a byte stream into a table bucket index.
// Depends on swh_pkg, swh_in_if and swh_out_if.
//
// One byte is taken per cycle while the result channel does not hold the
// pipeline, with no gaps needed between strings. Each byte passes an input
// register, a state update stage that folds bytes into words and sums them,
// and a mixing stage that drives the result register. Only the last byte of a
// string produces a request on the result channel. A stalled result holds the
// pipeline stages behind it only as they fill.
module string_word_hash_index_top #(
  parameter int INDEX_BITS = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  swh_in_if.sink        in_if,
  swh_out_if.source     out_if
);

  localparam int KeepBits = (INDEX_BITS < swh_pkg::OutBits) ? INDEX_BITS : swh_pkg::OutBits;
  localparam swh_pkg::index_t IdxMask = ~(swh_pkg::index_t'('1) << KeepBits);

  logic            a_valid_r;
  swh_pkg::byte_t  a_byte_r;
  logic            a_last_r;

  logic            b_valid_r;
  swh_pkg::word_t  h_r;

  logic            c_valid_r;
  swh_pkg::index_t c_index_r;

  swh_pkg::word_t  acc_r;
  swh_pkg::word_t  acc_nxt;
  swh_pkg::word_t  wb_r;
  swh_pkg::word_t  wb_nxt;
  swh_pkg::cnt_t   cnt_r;
  swh_pkg::cnt_t   cnt_nxt;
  swh_pkg::word_t  wb_new;
  swh_pkg::word_t  h_nxt;
  swh_pkg::word_t  mixed;

  logic c_load;
  logic b_load;
  logic a_load;

  assign c_load = b_valid_r && (!c_valid_r || out_if.ready);
  assign b_load = a_valid_r && (!b_valid_r || c_load);
  assign a_load = in_if.valid && in_if.ready;

  assign in_if.ready = !a_valid_r || b_load;

  always_comb begin
    wb_new  = (wb_r << 8) + swh_pkg::sext_byte(a_byte_r);
    h_nxt   = acc_r + swh_pkg::fold_word(wb_new);
    acc_nxt = acc_r;
    wb_nxt  = wb_new;
    cnt_nxt = cnt_r + swh_pkg::cnt_t'(1);
    if (cnt_r == swh_pkg::WordFullCnt) begin
      acc_nxt = h_nxt;
      wb_nxt  = '0;
      cnt_nxt = '0;
    end
    if (a_last_r) begin
      acc_nxt = '0;
      wb_nxt  = '0;
      cnt_nxt = '0;
    end
  end

  assign mixed = swh_pkg::mix_hash(h_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      acc_r     <= '0;
      wb_r      <= '0;
      cnt_r     <= '0;
    end else begin
      if (in_if.ready) begin
        a_valid_r <= in_if.valid;
      end
      if (b_load) begin
        acc_r <= acc_nxt;
        wb_r  <= wb_nxt;
        cnt_r <= cnt_nxt;
      end
      if (!b_valid_r || c_load) begin
        b_valid_r <= b_load && a_last_r;
      end
      if (!c_valid_r || out_if.ready) begin
        c_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_byte_r <= in_if.data_byte;
      a_last_r <= in_if.last_byte;
    end
    if (b_load && a_last_r) begin
      h_r <= h_nxt;
    end
    if (c_load) begin
      c_index_r <= mixed[swh_pkg::OutBits-1:0] & IdxMask;
    end
  end

  assign out_if.valid        = c_valid_r;
  assign out_if.bucket_index = c_index_r;

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    b_load && a_last_r |=> (cnt_r == '0) && (wb_r == '0) && (acc_r == '0))
    else $error("state not cleared after last byte");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    b_load && !a_last_r && (cnt_r != swh_pkg::WordFullCnt)
      |=> cnt_r == $past(cnt_r) + swh_pkg::cnt_t'(1))
    else $error("byte count did not advance");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !a_valid_r |-> in_if.ready)
    else $error("input stalled with empty input register");

  a_hold_hash: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && !c_load |=> b_valid_r && $stable(h_r))
    else $error("pending hash lost while stalled");

endmodule

[bench/string_word_hash_index_top_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for string_word_hash_index_top: drives byte strings, predicts each
// bucket index and checks the results in order. Depends on swh_pkg, swh_in_if, swh_out_if.
module string_word_hash_index_top_test;

  localparam int IndexBits  = 12;
  localparam int WatchLimit = 2000;
  localparam int DrainWait  = 8;

  logic clk;
  logic rst_n;

  swh_in_if  in_ch();
  swh_out_if out_ch();

  string_word_hash_index_top #(
    .INDEX_BITS(IndexBits)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  swh_pkg::word_t  str_sum;
  swh_pkg::word_t  str_word;
  swh_pkg::cnt_t   str_count;
  swh_pkg::index_t pending_buckets[$];

  bit idle_on;
  int hold_cycles;
  int fail_count;
  int bytes_sent;
  int strings_hashed;
  int buckets_checked;
  int idle_run;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic hash_byte(input swh_pkg::byte_t data, input logic last);
    swh_pkg::word_t h;
    logic [63:0]    mask;
    str_word = (str_word << 8) +
               {{(swh_pkg::WordBits-swh_pkg::ByteBits){data[swh_pkg::ByteBits-1]}}, data};
    if (str_count == swh_pkg::WordFullCnt) begin
      str_sum   = str_sum + (str_word ^ (str_word >> 3));
      str_word  = '0;
      str_count = '0;
    end else begin
      str_count = str_count + swh_pkg::cnt_t'(1);
    end
    if (last) begin
      h    = str_sum + (str_word ^ (str_word >> 3));
      h    = h + (h >> 11) + (h >> 13) + (h >> 23);
      mask = (64'd1 << IndexBits) - 64'd1;
      pending_buckets.push_back(swh_pkg::index_t'(h & mask[swh_pkg::WordBits-1:0]));
      str_sum   = '0;
      str_word  = '0;
      str_count = '0;
      strings_hashed++;
    end
  endtask

  task automatic send_byte(input swh_pkg::byte_t data, input logic last);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.last_byte <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    hash_byte(data, last);
    bytes_sent++;
  endtask

  // first byte of the string sits in the highest of the len low bytes
  task automatic send_packed(input logic [63:0] bytes, input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(bytes[8*(len-1-i) +: 8], i == len - 1);
    end
  endtask

  function automatic swh_pkg::byte_t pick_byte();
    swh_pkg::byte_t b;
    case ($urandom_range(0, 9))
      0: b = 8'h00;
      1: b = 8'hFF;
      2: b = 8'h80;
      3: b = 8'h7F;
      default: b = swh_pkg::byte_t'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  task automatic send_random_string(input int max_len);
    int len;
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, max_len) : $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      send_byte(pick_byte(), i == len - 1);
    end
  endtask

  task automatic test_directed();
    idle_on = 1'b0;
    send_packed(64'h00, 1);
    send_packed(64'h01, 1);
    send_packed(64'h7F, 1);
    send_packed(64'h80, 1);
    send_packed(64'hFF, 1);
    send_packed(64'h807F, 2);
    send_packed(64'hFF0180, 3);
    send_packed(64'hFFFFFFFF, 4);
    send_packed(64'h7F800055, 4);
    send_packed(64'h4142434445, 5);
  endtask

  task automatic test_random_strings(input int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      idle_on = ((bytes_sent / 150) % 3) != 2;
      send_random_string(40);
    end
  endtask

  task automatic test_backpressure(input int n_bytes);
    int stop_at;
    idle_on     = 1'b0;
    hold_cycles = 300;
    stop_at     = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_string(3);
    while (hold_cycles > 0) @(posedge clk);
  endtask

  task automatic test_streaming(input int n_bytes);
    int stop_at;
    idle_on = 1'b0;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_string(12);
  endtask

  initial begin : result_checker
    int              stall;
    swh_pkg::index_t want;
    stall        = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_buckets.size() == 0) begin
          note_failure($sformatf("unexpected bucket index %0d", out_ch.bucket_index));
        end else begin
          want = pending_buckets.pop_front();
          if (out_ch.bucket_index !== want)
            note_failure($sformatf("bucket_index expected %0d, got %0d",
                                   want, out_ch.bucket_index));
          buckets_checked++;
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 8) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stall_watch
    idle_run = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
      if (idle_run >= WatchLimit) begin
        $display("Timeout: no request moved for %0d cycles", WatchLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : main_sequence
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    idle_on         = 1'b0;
    hold_cycles     = 0;
    fail_count      = 0;
    bytes_sent      = 0;
    strings_hashed  = 0;
    buckets_checked = 0;
    str_sum         = '0;
    str_word        = '0;
    str_count       = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_strings(1400);
    test_backpressure(120);
    test_streaming(300);

    in_ch.valid <= 1'b0;
    while (pending_buckets.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("Hashed %0d strings from %0d bytes, %0d bucket indexes checked, %0d failures",
             strings_hashed, bytes_sent, buckets_checked, fail_count);
    $display("Covered sign-extended extremes, word-aligned tails, random stalls and a long hold");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
